FILE: rtl/mwfb_pkg.sv
package mwfb_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMB_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPD_START  = 3'd3;

  localparam logic [7:0]  RST_SLAVE_ADDR = 8'd1;
  localparam logic [15:0] RST_COMB_START = 16'd6146;
  localparam logic [15:0] RST_POS_START  = 16'd1026;
  localparam logic [15:0] RST_SPD_START  = 16'd1282;

  localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL    = 16'hA001;

  localparam logic [7:0] QTY_COMB    = 8'h04;
  localparam logic [7:0] QTY_SPLIT   = 8'h02;
  localparam logic [7:0] NBYTES_COMB  = 8'h08;
  localparam logic [7:0] NBYTES_SPLIT = 8'h04;

  // Byte positions within a frame
  localparam logic [4:0] IDX_ADDR    = 5'd0;
  localparam logic [4:0] IDX_FUNC    = 5'd1;
  localparam logic [4:0] IDX_REG_HI  = 5'd2;
  localparam logic [4:0] IDX_REG_LO  = 5'd3;
  localparam logic [4:0] IDX_QTY_HI  = 5'd4;
  localparam logic [4:0] IDX_QTY_LO  = 5'd5;
  localparam logic [4:0] IDX_NBYTES  = 5'd6;
  localparam logic [4:0] IDX_WA_B3   = 5'd7;
  localparam logic [4:0] IDX_WA_B2   = 5'd8;
  localparam logic [4:0] IDX_WA_B1   = 5'd9;
  localparam logic [4:0] IDX_WA_B0   = 5'd10;
  localparam logic [4:0] IDX_WB_B3   = 5'd11;
  localparam logic [4:0] IDX_WB_B2   = 5'd12;
  localparam logic [4:0] IDX_WB_B1   = 5'd13;
  localparam logic [4:0] IDX_WB_B0   = 5'd14;

  // First CRC byte position, and final byte position, per frame kind
  localparam logic [4:0] BODY_LEN_COMB   = 5'd15;
  localparam logic [4:0] BODY_LEN_SPLIT  = 5'd11;
  localparam logic [4:0] FRAME_LAST_COMB  = 5'd16;
  localparam logic [4:0] FRAME_LAST_SPLIT = 5'd12;

  localparam logic OP_COMBINED = 1'b0;
  localparam logic OP_SPLIT    = 1'b1;

  typedef struct packed {
    logic       load;       // word accepted: latch operands
    logic       emit;       // produce one byte into the output register
    logic       op;
    logic       phase;
    logic [4:0] idx;
    logic       frame_end;
    logic       last;
  } mwfb_cmd_t;

  typedef struct packed {
    logic out_free;
  } mwfb_sts_t;

  // Reflected CRC-16/MODBUS over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/mwfb_in_if.sv
interface mwfb_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] location;
  logic [31:0] speed;

  modport source(output valid, output op, output location, output speed, input ready);
  modport sink(input valid, input op, input location, input speed, output ready);
endinterface

FILE: rtl/mwfb_out_if.sv
interface mwfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;
  logic       last;

  modport source(output valid, output data_byte, output frame_end, output last, input ready);
  modport sink(input valid, input data_byte, input frame_end, input last, output ready);
endinterface

FILE: rtl/mwfb_ctrl.sv
module mwfb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  mwfb_pkg::mwfb_sts_t sts_i,
  output mwfb_pkg::mwfb_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEND = 1'b1;

  logic       state_r, state_nxt;
  logic       op_r, op_nxt;
  logic       phase_r, phase_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] last_idx;
  logic       load, emit, at_end;

  assign in_ready = (state_r == ST_IDLE);
  assign load     = in_valid && in_ready;
  assign emit     = (state_r == ST_SEND) && sts_i.out_free;
  assign last_idx = (op_r == mwfb_pkg::OP_SPLIT) ? mwfb_pkg::FRAME_LAST_SPLIT
                                                 : mwfb_pkg::FRAME_LAST_COMB;
  assign at_end   = (idx_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (load) begin
          op_nxt    = in_op;
          phase_nxt = 1'b0;
          idx_nxt   = 5'd0;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (emit) begin
          if (!at_end) begin
            idx_nxt = idx_r + 5'd1;
          end else if (op_r == mwfb_pkg::OP_SPLIT && !phase_r) begin
            // advance to the speed frame
            idx_nxt   = 5'd0;
            phase_nxt = 1'b1;
          end else begin
            idx_nxt   = 5'd0;
            phase_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= mwfb_pkg::OP_COMBINED;
      phase_r <= 1'b0;
      idx_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    cmd_o.load      = load;
    cmd_o.emit      = emit;
    cmd_o.op        = op_r;
    cmd_o.phase     = phase_r;
    cmd_o.idx       = idx_r;
    cmd_o.frame_end = at_end;
    cmd_o.last      = at_end && (op_r == mwfb_pkg::OP_COMBINED || phase_r);
  end

`ifndef SYNTH
  a_load_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (state_r == ST_SEND && idx_r == 5'd0 && !phase_r))
    else $error("accepted word did not start a fresh frame");

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (idx_r <= last_idx))
    else $error("byte index ran past the end of the frame");

  a_phase_only_split: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (op_r == mwfb_pkg::OP_SPLIT && state_r == ST_SEND))
    else $error("second frame phase outside a split word");
`endif

endmodule

FILE: rtl/mwfb_datapath.sv
module mwfb_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [mwfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwfb_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic [31:0]                        in_location,
  input  logic [31:0]                        in_speed,
  input  mwfb_pkg::mwfb_cmd_t                cmd_i,
  output mwfb_pkg::mwfb_sts_t                sts_o,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_data_byte,
  output logic                               out_frame_end,
  output logic                               out_last
);

  logic [7:0]  slave_addr_r;
  logic [15:0] comb_start_r, pos_start_r, spd_start_r;
  logic [31:0] loc_r, spd_r;
  logic [15:0] crc_r, crc_base;
  logic        out_valid_r;
  logic [7:0]  data_r;
  logic        fend_r, last_r;

  logic [15:0] start_reg;
  logic [31:0] word_a;
  logic [7:0]  qty, nbytes, byte_val;
  logic [4:0]  body_len;
  logic        is_body;

  assign sts_o.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mwfb_pkg::RST_SLAVE_ADDR;
      comb_start_r <= mwfb_pkg::RST_COMB_START;
      pos_start_r  <= mwfb_pkg::RST_POS_START;
      spd_start_r  <= mwfb_pkg::RST_SPD_START;
    end else if (cfg_we) begin
      case (cfg_index)
        mwfb_pkg::CFG_SLAVE_ADDR: slave_addr_r <= cfg_wdata[7:0];
        mwfb_pkg::CFG_COMB_START: comb_start_r <= cfg_wdata;
        mwfb_pkg::CFG_POS_START:  pos_start_r  <= cfg_wdata;
        mwfb_pkg::CFG_SPD_START:  spd_start_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      loc_r <= in_location;
      spd_r <= in_speed;
    end
  end

  always_comb begin
    if (cmd_i.op == mwfb_pkg::OP_COMBINED) begin
      start_reg = comb_start_r;
      word_a    = loc_r;
      qty       = mwfb_pkg::QTY_COMB;
      nbytes    = mwfb_pkg::NBYTES_COMB;
      body_len  = mwfb_pkg::BODY_LEN_COMB;
    end else begin
      start_reg = cmd_i.phase ? spd_start_r : pos_start_r;
      word_a    = cmd_i.phase ? spd_r : loc_r;
      qty       = mwfb_pkg::QTY_SPLIT;
      nbytes    = mwfb_pkg::NBYTES_SPLIT;
      body_len  = mwfb_pkg::BODY_LEN_SPLIT;
    end
  end

  assign crc_base = (cmd_i.idx == mwfb_pkg::IDX_ADDR) ? mwfb_pkg::CRC_INIT : crc_r;
  assign is_body  = (cmd_i.idx < body_len);

  always_comb begin
    if (cmd_i.idx == body_len) begin
      byte_val = crc_r[7:0];
    end else if (cmd_i.idx == body_len + 5'd1) begin
      byte_val = crc_r[15:8];
    end else begin
      case (cmd_i.idx)
        mwfb_pkg::IDX_ADDR:   byte_val = slave_addr_r;
        mwfb_pkg::IDX_FUNC:   byte_val = mwfb_pkg::FUNC_WRITE_MULTI;
        mwfb_pkg::IDX_REG_HI: byte_val = start_reg[15:8];
        mwfb_pkg::IDX_REG_LO: byte_val = start_reg[7:0];
        mwfb_pkg::IDX_QTY_HI: byte_val = 8'h00;
        mwfb_pkg::IDX_QTY_LO: byte_val = qty;
        mwfb_pkg::IDX_NBYTES: byte_val = nbytes;
        mwfb_pkg::IDX_WA_B3:  byte_val = word_a[31:24];
        mwfb_pkg::IDX_WA_B2:  byte_val = word_a[23:16];
        mwfb_pkg::IDX_WA_B1:  byte_val = word_a[15:8];
        mwfb_pkg::IDX_WA_B0:  byte_val = word_a[7:0];
        mwfb_pkg::IDX_WB_B3:  byte_val = spd_r[31:24];
        mwfb_pkg::IDX_WB_B2:  byte_val = spd_r[23:16];
        mwfb_pkg::IDX_WB_B1:  byte_val = spd_r[15:8];
        mwfb_pkg::IDX_WB_B0:  byte_val = spd_r[7:0];
        default:              byte_val = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mwfb_pkg::CRC_INIT;
    end else if (cmd_i.emit && is_body) begin
      crc_r <= mwfb_pkg::crc_byte(crc_base, byte_val);
    end
  end

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit) begin
      data_r <= byte_val;
      fend_r <= cmd_i.frame_end;
      last_r <= cmd_i.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = data_r;
  assign out_frame_end = fend_r;
  assign out_last      = last_r;

`ifndef SYNTH
  a_emit_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> (!out_valid_r || out_ready))
    else $error("byte produced over an untaken one");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(data_r)))
    else $error("stalled byte changed or dropped");

  a_last_is_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.emit && cmd_i.last) |-> cmd_i.frame_end)
    else $error("last byte not at a frame end");
`endif

endmodule

FILE: rtl/modbus_write_frame_builder_core.sv
// Modbus RTU write-multiple-registers frame builder.
// Input channel in_ch takes one word: op, location and speed. Op 0 yields
// one 17-byte frame carrying both values; op 1 yields a 13-byte location
// frame then a 13-byte speed frame. Each frame closes with CRC-16/MODBUS,
// low byte first. Result channel out_ch moves one frame byte per word,
// flagged frame_end on the final CRC byte of each frame and last on the
// final byte caused by the input word.
// The configuration port writes slave address and start registers on any
// edge with cfg_we high; write only while the block is idle.
// Timing: in_ch.ready is high only while no frame is being built. After
// acceptance the first byte is registered once the output register is free,
// then one byte per cycle from the byte sequencer while the receiver does
// not stall. The next word may be accepted while the final byte still
// waits in the output register.
// When the receiver stalls, hold the current byte and pause the sequencer.
// Synchronous reset (rst_n low) empties the output register, returns the
// sequencer to idle and restores the default register values.
module modbus_write_frame_builder_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mwfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mwfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
  mwfb_in_if.sink                         in_ch,
  mwfb_out_if.source                      out_ch
);

  mwfb_pkg::mwfb_cmd_t cmd;
  mwfb_pkg::mwfb_sts_t sts;
  logic                in_ready;

  assign in_ch.ready = in_ready;

  // controller: byte sequencing and frame phase
  mwfb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // datapath: operands, registers, byte select, CRC and output register
  mwfb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_location   (in_ch.location),
    .in_speed      (in_ch.speed),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data_byte (out_ch.data_byte),
    .out_frame_end (out_ch.frame_end),
    .out_last      (out_ch.last)
  );

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Timeout: allow several times the length of the worst correct run.
  localparam int CYCLE_LIMIT    = 400000;
  localparam int MAX_REPORTS    = 10;
  localparam int TAIL_CYCLES    = 40;
  localparam int RANDOM_PHASES  = 5;
  localparam int WORDS_PER_PHASE = 26;

  // One motion command as presented on the input channel. A drain command
  // is held back until every frame byte already owed has come out.
  typedef struct {
    logic        op;
    logic [31:0] location;
    logic [31:0] speed;
    bit          drain;
  } motion_cmd_t;

  // One byte of a Modbus frame as it should appear on the result channel.
  typedef struct {
    logic [7:0] data_byte;
    logic       frame_end;
    logic       last;
  } wire_byte_t;

  logic clk;
  logic rst_n;
  logic                            cfg_we;
  logic [mwfb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mwfb_pkg::CFG_DATA_W-1:0] cfg_wdata;

  mwfb_in_if  in_ch();
  mwfb_out_if out_ch();

  modbus_write_frame_builder_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Shadow copies of the register file, kept in step with every write.
  logic [7:0]  addr_shadow;
  logic [15:0] comb_start_shadow;
  logic [15:0] pos_start_shadow;
  logic [15:0] spd_start_shadow;

  motion_cmd_t pending_q[$];  // commands not yet offered to the block
  wire_byte_t  frame_q[$];    // frame bytes predicted but not yet seen

  wire_byte_t  want;
  motion_cmd_t cur_cmd;

  bit in_fire;
  bit out_fire;
  bit quiet;                  // suppress idling on both sides
  int in_gap;
  int out_stall;
  int cycle_count;
  int mismatches;
  int bytes_checked;
  int words_combined;
  int words_split;
  int reg_writes;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reflected CRC-16/MODBUS, one data bit at a time, least significant first.
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                    input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ data[k];
      r  = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ mwfb_pkg::CRC_POLY_REFL;
      end
    end
    return r;
  endfunction

  // Build one write-multiple-registers frame and append its bytes to the
  // expected stream. A combined frame carries two 32-bit values, a split
  // frame one; closes_item marks the final frame of the input word.
  task automatic queue_frame(input logic [15:0] start_reg, input logic [31:0] w0,
                             input logic [31:0] w1, input bit two_values,
                             input bit closes_item);
    logic [7:0]  body[$];
    logic [15:0] crc;
    wire_byte_t  wb;
    body.push_back(addr_shadow);
    body.push_back(mwfb_pkg::FUNC_WRITE_MULTI);
    body.push_back(start_reg[15:8]);
    body.push_back(start_reg[7:0]);
    body.push_back(8'h00);
    body.push_back(two_values ? mwfb_pkg::QTY_COMB : mwfb_pkg::QTY_SPLIT);
    body.push_back(two_values ? mwfb_pkg::NBYTES_COMB : mwfb_pkg::NBYTES_SPLIT);
    // Values go out big-endian
    for (int k = 3; k >= 0; k--) begin
      body.push_back(w0[8*k +: 8]);
    end
    if (two_values) begin
      for (int k = 3; k >= 0; k--) begin
        body.push_back(w1[8*k +: 8]);
      end
    end
    crc = mwfb_pkg::CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_modbus_step(crc, body[i]);
      wb  = '{data_byte: body[i], frame_end: 1'b0, last: 1'b0};
      frame_q.push_back(wb);
    end
    // CRC trails the body, low byte first
    wb = '{data_byte: crc[7:0], frame_end: 1'b0, last: 1'b0};
    frame_q.push_back(wb);
    wb = '{data_byte: crc[15:8], frame_end: 1'b1, last: closes_item};
    frame_q.push_back(wb);
  endtask

  // Expected output for one accepted input word.
  task automatic predict_frames(input logic op, input logic [31:0] location,
                                input logic [31:0] speed);
    if (op == mwfb_pkg::OP_COMBINED) begin
      words_combined++;
      queue_frame(comb_start_shadow, location, speed, 1'b1, 1'b1);
    end else begin
      words_split++;
      queue_frame(pos_start_shadow, location, 32'h0, 1'b0, 1'b0);
      queue_frame(spd_start_shadow, speed, 32'h0, 1'b0, 1'b1);
    end
  endtask

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Sample both channels at the rising edge. Record the handshakes so the
  // falling-edge processes know whether their word moved.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    in_fire     <= rst_n && in_ch.valid && in_ch.ready;
    out_fire    <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      bytes_checked++;
      if (frame_q.size() == 0) begin
        log_mismatch($sformatf("byte %02h (end %b last %b) with nothing expected",
                               out_ch.data_byte, out_ch.frame_end, out_ch.last));
      end else begin
        want = frame_q.pop_front();
        if (out_ch.data_byte !== want.data_byte || out_ch.frame_end !== want.frame_end ||
            out_ch.last !== want.last) begin
          log_mismatch($sformatf(
            "byte %0d: expected data %02h end %b last %b, got data %02h end %b last %b",
            bytes_checked, want.data_byte, want.frame_end, want.last,
            out_ch.data_byte, out_ch.frame_end, out_ch.last));
        end
      end
    end
    // Predict after the compare: a newly taken word's bytes come out later
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_frames(in_ch.op, in_ch.location, in_ch.speed);
    end
  end

  // Sender: change inputs on the falling edge. Hold a word until it is
  // taken, then idle for the gap drawn with it before offering the next.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_fire) begin
      // hold: the block has not taken this word yet
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap = in_gap - 1;
    end else if (pending_q.size() != 0 && !(pending_q[0].drain && frame_q.size() != 0)) begin
      cur_cmd = pending_q.pop_front();
      in_ch.valid    <= 1'b1;
      in_ch.op       <= cur_cmd.op;
      in_ch.location <= cur_cmd.location;
      in_ch.speed    <= cur_cmd.speed;
      in_gap = quiet ? 0 : $urandom_range(0, 14);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Receiver: after each byte taken, drop ready for a drawn number of cycles.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_fire) begin
      out_stall = quiet ? 0 : $urandom_range(0, 14);
      out_ch.ready <= (out_stall == 0);
    end else if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ch.ready <= (out_stall == 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d frame bytes still owed", cycle_count,
             frame_q.size());
    $display("FAIL modbus_write_frame_builder_core");
    $finish;
  end

  task automatic push_cmd(input logic op, input logic [31:0] location,
                          input logic [31:0] speed, input bit drain);
    motion_cmd_t c;
    c = '{op: op, location: location, speed: speed, drain: drain};
    pending_q.push_back(c);
  endtask

  // Random value with a bias towards the extremes.
  function automatic logic [31:0] pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      return 32'h0;
    end else if (kind == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom();
  endfunction

  // Wait until every queued word has gone in and every frame byte has come out.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_ch.valid || frame_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Register write on the falling edge; the block takes it at the next rise.
  task automatic write_reg(input logic [mwfb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mwfb_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    reg_writes++;
    // Keep only the register's own width; unknown indexes change nothing
    case (idx)
      mwfb_pkg::CFG_SLAVE_ADDR: addr_shadow = val[7:0];
      mwfb_pkg::CFG_COMB_START: comb_start_shadow = val[15:0];
      mwfb_pkg::CFG_POS_START:  pos_start_shadow = val[15:0];
      mwfb_pkg::CFG_SPD_START:  spd_start_shadow = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    int phase;
    // Drive every input to a known value from time zero
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.op       = mwfb_pkg::OP_COMBINED;
    in_ch.location = '0;
    in_ch.speed    = '0;
    out_ch.ready   = 1'b0;
    quiet          = 1'b0;
    in_gap         = 0;
    out_stall      = 0;
    cycle_count    = 0;
    mismatches     = 0;
    bytes_checked  = 0;
    words_combined = 0;
    words_split    = 0;
    reg_writes     = 0;
    addr_shadow       = mwfb_pkg::RST_SLAVE_ADDR;
    comb_start_shadow = mwfb_pkg::RST_COMB_START;
    pos_start_shadow  = mwfb_pkg::RST_POS_START;
    spd_start_shadow  = mwfb_pkg::RST_SPD_START;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset register values: both frame kinds, field extremes, alternating bits
    push_cmd(mwfb_pkg::OP_COMBINED, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'h0000_0000, 32'h0000_0000, 1'b0);
    push_cmd(mwfb_pkg::OP_COMBINED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    push_cmd(mwfb_pkg::OP_COMBINED, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    // Hold off the sender until all owed bytes have drained
    push_cmd(mwfb_pkg::OP_COMBINED, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'h8000_0001, 32'h0000_8000, 1'b0);
    wait_idle();

    // All-ones registers; the address write carries bits above its width
    write_reg(mwfb_pkg::CFG_SLAVE_ADDR, 16'hFFFF);
    write_reg(mwfb_pkg::CFG_COMB_START, 16'hFFFF);
    write_reg(mwfb_pkg::CFG_POS_START,  16'hFFFF);
    write_reg(mwfb_pkg::CFG_SPD_START,  16'hFFFF);
    // Indexes past the register list must be ignored
    for (n = mwfb_pkg::CFG_SPD_START + 1; n < (1 << mwfb_pkg::CFG_IDX_W); n++) begin
      write_reg(n[mwfb_pkg::CFG_IDX_W-1:0], 16'h5A5A);
    end
    push_cmd(mwfb_pkg::OP_COMBINED, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'hDEAD_BEEF, 32'hCAFE_F00D, 1'b0);
    wait_idle();

    // All-zero registers; the address write has only high bits set
    write_reg(mwfb_pkg::CFG_SLAVE_ADDR, 16'hFF00);
    write_reg(mwfb_pkg::CFG_COMB_START, 16'h0000);
    write_reg(mwfb_pkg::CFG_POS_START,  16'h0000);
    write_reg(mwfb_pkg::CFG_SPD_START,  16'h0000);
    push_cmd(mwfb_pkg::OP_COMBINED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    push_cmd(mwfb_pkg::OP_SPLIT,    32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    push_cmd(mwfb_pkg::OP_COMBINED, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0);

    // Random words over a series of register settings. Phase one runs with
    // no idling at all; phase three puts every register at its maximum.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      if (phase == 3) begin
        write_reg(mwfb_pkg::CFG_SLAVE_ADDR, 16'h00FF);
        write_reg(mwfb_pkg::CFG_COMB_START, 16'hFFFF);
        write_reg(mwfb_pkg::CFG_POS_START,  16'hFFFF);
        write_reg(mwfb_pkg::CFG_SPD_START,  16'hFFFF);
      end else begin
        write_reg(mwfb_pkg::CFG_SLAVE_ADDR, 16'($urandom_range(0, 65535)));
        write_reg(mwfb_pkg::CFG_COMB_START, 16'($urandom_range(0, 65535)));
        write_reg(mwfb_pkg::CFG_POS_START,  16'($urandom_range(0, 65535)));
        write_reg(mwfb_pkg::CFG_SPD_START,  16'($urandom_range(0, 65535)));
      end
      quiet = (phase == 1);
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        push_cmd(1'($urandom_range(0, 1)), pick_value(), pick_value(),
                 $urandom_range(0, 19) == 0);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d input words (%0d combined, %0d split) and %0d frame bytes",
             words_combined + words_split, words_combined, words_split, bytes_checked);
    $display("over %0d register writes, from all-zero to all-ones settings; %0d mismatches",
             reg_writes, mismatches);
    if (mismatches == 0 && frame_q.size() == 0) begin
      $display("PASS modbus_write_frame_builder_core");
    end else begin
      $display("FAIL modbus_write_frame_builder_core");
    end
    $finish;
  end

endmodule
